// ===== src/subtitle_timing_line_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the subtitle timing line parser
// Shorthand for clocked concurrent assertions, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef SUBTITLE_TIMING_LINE_PARSER_TOP_ASSERT_SVH
`define SUBTITLE_TIMING_LINE_PARSER_TOP_ASSERT_SVH

// checked only outside reset
`define STLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define STLP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/stlp_pkg.sv =====
// ----------------------------------------------------------------------------
// stlp_pkg
// Shared types and constants of the subtitle timing line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stlp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    CLS_IGNORE = 3'd0,
    CLS_WS     = 3'd1,
    CLS_DIGIT  = 3'd2,
    CLS_COLON  = 3'd3,
    CLS_SEP    = 3'd4,
    CLS_OTHER  = 3'd5
  } token_class_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_ARROW  = 2'd1,
    STATUS_MALFORMED = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    token_class_t cls;
    logic [3:0]   digit;
    logic         flush;
    logic         last;
    logic         arrow;
  } token_t;

endpackage

// ===== src/stlp_front.sv =====
// ----------------------------------------------------------------------------
// stlp_front
// Arrow search and byte classification; turns each byte into a token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  output logic             tok_valid,
  input  logic             tok_ready,
  output stlp_pkg::token_t tok
);
  import stlp_pkg::*;

  logic       arrow_seen;
  logic       arrow_seen_next;
  logic [1:0] dash_run;
  logic [1:0] dash_run_next;
  token_class_t cls;

  always_comb begin
    if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (s_tdata == CH_COLON) begin
      cls = CLS_COLON;
    end else if (s_tdata == CH_DOT || s_tdata == CH_COMMA) begin
      cls = CLS_SEP;
    end else if (s_tdata == CH_SPACE || (s_tdata >= CH_TAB && s_tdata <= CH_CR)) begin
      cls = CLS_WS;
    end else begin
      cls = CLS_OTHER;
    end
  end

  always_comb begin
    arrow_seen_next = arrow_seen;
    dash_run_next   = dash_run;
    tok.cls   = CLS_IGNORE;
    tok.digit = 4'(s_tdata - CH_ZERO);
    tok.flush = 1'b0;
    tok.last  = s_tlast;
    if (!arrow_seen) begin
      if (s_tdata == CH_DASH) begin
        if (dash_run == 2'd2) begin
          tok.cls = CLS_OTHER;
        end else begin
          dash_run_next = dash_run + 2'd1;
        end
      end else if (s_tdata == CH_GT && dash_run == 2'd2) begin
        arrow_seen_next = 1'b1;
        dash_run_next   = '0;
      end else begin
        tok.flush     = (dash_run != 2'd0);
        dash_run_next = '0;
        tok.cls       = cls;
      end
    end
    tok.arrow = arrow_seen_next;
  end

  assign tok_valid = s_tvalid;
  assign s_tready  = tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrow_seen <= 1'b0;
      dash_run   <= '0;
    end else if (s_tvalid && tok_ready) begin
      if (s_tlast) begin
        arrow_seen <= 1'b0;
        dash_run   <= '0;
      end else begin
        arrow_seen <= arrow_seen_next;
        dash_run   <= dash_run_next;
      end
    end
  end

endmodule

// ===== src/stlp_queue.sv =====
// ----------------------------------------------------------------------------
// stlp_queue
// Small token queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  stlp_pkg::token_t in_tok,
  output logic             out_valid,
  input  logic             out_ready,
  output stlp_pkg::token_t out_tok
);
  import stlp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  token_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_tok   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== src/stlp_back.sv =====
// ----------------------------------------------------------------------------
// stlp_back
// Timestamp field parser and end-of-line millisecond conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlp_back #(
  parameter int  TIME_BITS = 48,
  localparam int OUT_W     = ((TIME_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  stlp_pkg::token_t tok,
  input  logic [1:0]       min_frac,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);
  import stlp_pkg::*;

  typedef enum logic [4:0] {
    ST_PARSE = 5'b00001,
    ST_HM    = 5'b00010,
    ST_MS    = 5'b00100,
    ST_FRAC  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FLEAD = 4'b0100,
    PH_FRAC  = 4'b1000
  } phase_t;

  localparam int MW = TIME_BITS + 11;
  localparam int DW = TIME_BITS + 4;
  localparam logic [TIME_BITS-1:0] LIMIT = '1;

  state_t               state;
  phase_t               phase;
  phase_t               phase_next;
  logic [1:0]           colon_count;
  logic [1:0]           colon_count_next;
  logic [TIME_BITS-1:0] fields [0:2];
  logic                 has_digit;
  logic                 has_digit_next;
  logic [9:0]           frac_val;
  logic [9:0]           frac_val_next;
  logic [1:0]           frac_cnt;
  logic [1:0]           frac_cnt_next;
  logic                 pend_space;
  logic                 pend_space_next;
  logic                 err_mal;
  logic                 err_mal_next;
  logic                 err_ovf;
  logic                 err_ovf_next;
  logic                 arrow;
  logic [TIME_BITS-1:0] total;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_data;

  logic                 fld_we;
  logic [DW-1:0]        dig_sum;
  logic                 dig_ovf;
  logic [TIME_BITS-1:0] dig_res;
  logic                 int_path;
  logic                 frac_path;

  logic [TIME_BITS-1:0] mul_a;
  logic [9:0]           mul_k;
  logic [TIME_BITS-1:0] mul_b;
  logic [MW-1:0]        mul_sum;
  logic                 mul_ovf;
  logic [TIME_BITS-1:0] mul_res;
  logic [TIME_BITS-1:0] h_sel;
  logic [TIME_BITS-1:0] m_sel;
  logic [TIME_BITS-1:0] s_sel;
  logic [9:0]           frac_ms;
  status_t              status;
  logic [TIME_BITS-1:0] start_ms;
  logic                 load_out;

  assign tok_ready = (state == ST_PARSE);

  // field digit accumulate, saturating
  assign dig_sum = {4'b0, fields[colon_count]} * DW'(10) + DW'(tok.digit);
  assign dig_ovf = |dig_sum[DW-1:TIME_BITS];
  assign dig_res = dig_ovf ? LIMIT : dig_sum[TIME_BITS-1:0];

  always_comb begin
    phase_next       = phase;
    colon_count_next = colon_count;
    has_digit_next   = has_digit;
    frac_val_next    = frac_val;
    frac_cnt_next    = frac_cnt;
    pend_space_next  = pend_space;
    err_mal_next     = err_mal;
    err_ovf_next     = err_ovf;
    fld_we           = 1'b0;
    int_path         = 1'b0;
    frac_path        = 1'b0;

    if (tok.flush && !(phase == PH_FRAC && frac_cnt == 2'd3)) begin
      err_mal_next = 1'b1;
    end

    if (tok.cls != CLS_IGNORE) begin
      unique case (phase)
        PH_LEAD: begin
          if (tok.cls != CLS_WS) begin
            phase_next = PH_INT;
            int_path   = 1'b1;
          end
        end
        PH_INT: begin
          int_path = 1'b1;
        end
        PH_FLEAD: begin
          if (tok.cls != CLS_WS) begin
            phase_next = PH_FRAC;
            frac_path  = 1'b1;
          end
        end
        PH_FRAC: begin
          frac_path = 1'b1;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    if (int_path) begin
      case (tok.cls)
        CLS_DIGIT: begin
          fld_we         = 1'b1;
          has_digit_next = 1'b1;
          err_ovf_next   = err_ovf | dig_ovf;
        end
        CLS_COLON: begin
          if (!has_digit || colon_count == 2'd2) begin
            err_mal_next = 1'b1;
          end else begin
            colon_count_next = colon_count + 2'd1;
          end
          has_digit_next = 1'b0;
        end
        CLS_SEP: begin
          if (!has_digit) begin
            err_mal_next = 1'b1;
          end
          phase_next = PH_FLEAD;
        end
        default: begin
          err_mal_next = 1'b1;
        end
      endcase
    end

    if (frac_path && frac_cnt != 2'd3) begin
      if (tok.cls == CLS_WS) begin
        pend_space_next = 1'b1;
      end else begin
        if (pend_space) begin
          err_mal_next = 1'b1;
        end
        pend_space_next = 1'b0;
        if (tok.cls == CLS_DIGIT) begin
          frac_val_next = 10'({4'b0, frac_val} * 14'd10 + 14'(tok.digit));
        end else begin
          err_mal_next = 1'b1;
        end
        frac_cnt_next = frac_cnt + 2'd1;
      end
    end
  end

  always_comb begin
    h_sel = '0;
    m_sel = '0;
    s_sel = fields[0];
    if (colon_count == 2'd1) begin
      m_sel = fields[0];
      s_sel = fields[1];
    end else if (colon_count == 2'd2) begin
      h_sel = fields[0];
      m_sel = fields[1];
      s_sel = fields[2];
    end
  end

  always_comb begin
    case (frac_cnt)
      2'd0:    frac_ms = '0;
      2'd1:    frac_ms = 10'(frac_val * 10'd100);
      2'd2:    frac_ms = 10'(frac_val * 10'd10);
      default: frac_ms = frac_val;
    endcase
  end

  // shared multiply-add, saturating
  always_comb begin
    unique case (state)
      ST_HM: begin
        mul_a = h_sel;
        mul_k = 10'd60;
        mul_b = m_sel;
      end
      ST_MS: begin
        mul_a = total;
        mul_k = 10'd60;
        mul_b = s_sel;
      end
      default: begin
        mul_a = total;
        mul_k = 10'd1000;
        mul_b = TIME_BITS'(frac_ms);
      end
    endcase
  end

  assign mul_sum = MW'(mul_a) * MW'(mul_k) + MW'(mul_b);
  assign mul_ovf = |mul_sum[MW-1:TIME_BITS];
  assign mul_res = mul_ovf ? LIMIT : mul_sum[TIME_BITS-1:0];

  always_comb begin
    if (!arrow) begin
      status = STATUS_NO_ARROW;
    end else if (err_mal) begin
      status = STATUS_MALFORMED;
    end else if (err_ovf) begin
      status = STATUS_OVERFLOW;
    end else begin
      status = STATUS_OK;
    end
    start_ms = (status == STATUS_OK) ? total : '0;
  end

  assign load_out = (state == ST_DONE) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= OUT_W'({start_ms, status});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_PARSE;
      phase       <= PH_LEAD;
      colon_count <= '0;
      fields[0]   <= '0;
      fields[1]   <= '0;
      fields[2]   <= '0;
      has_digit   <= 1'b0;
      frac_val    <= '0;
      frac_cnt    <= '0;
      pend_space  <= 1'b0;
      err_mal     <= 1'b0;
      err_ovf     <= 1'b0;
      arrow       <= 1'b0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_PARSE: begin
          if (tok_valid) begin
            phase       <= phase_next;
            colon_count <= colon_count_next;
            has_digit   <= has_digit_next;
            frac_val    <= frac_val_next;
            frac_cnt    <= frac_cnt_next;
            pend_space  <= pend_space_next;
            err_mal     <= err_mal_next;
            err_ovf     <= err_ovf_next;
            if (fld_we) begin
              fields[colon_count] <= dig_res;
            end
            if (tok.last) begin
              arrow <= tok.arrow;
              state <= ST_HM;
            end
          end
        end
        ST_HM: begin
          if (phase == PH_LEAD || phase == PH_INT || frac_cnt < min_frac) begin
            err_mal <= 1'b1;
          end
          total   <= mul_res;
          err_ovf <= err_ovf | mul_ovf;
          state   <= ST_MS;
        end
        ST_MS: begin
          total   <= mul_res;
          err_ovf <= err_ovf | mul_ovf;
          state   <= ST_FRAC;
        end
        ST_FRAC: begin
          total   <= mul_res;
          err_ovf <= err_ovf | mul_ovf;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            // clear line state for the next line
            phase       <= PH_LEAD;
            colon_count <= '0;
            fields[0]   <= '0;
            fields[1]   <= '0;
            fields[2]   <= '0;
            has_digit   <= 1'b0;
            frac_val    <= '0;
            frac_cnt    <= '0;
            pend_space  <= 1'b0;
            err_mal     <= 1'b0;
            err_ovf     <= 1'b0;
            arrow       <= 1'b0;
            state       <= ST_PARSE;
          end
        end
        default: begin
          state <= ST_PARSE;
        end
      endcase
    end
  end

endmodule

// ===== src/subtitle_timing_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// subtitle_timing_line_parser_top
// Start time of one subtitle cue line, in milliseconds.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one byte of a text line per beat, with tlast on
//   the final byte. For each line one result beat leaves on the master
//   channel: a status and the start time found before the first "-->".
//   The config channel writes min_fraction_digits; write it only while idle.
// Flow:
//   Bytes are taken at one per cycle while the token queue has room. After
//   the last byte of a line is accepted, its token passes through the queue
//   and the back end, when free, steps through ST_HM, ST_MS, ST_FRAC and
//   ST_DONE: three passes through one shared multiply-add unit plus the
//   result load into the output register. A four-entry token queue lets
//   the input keep flowing meanwhile.
// Reset:
//   Clears all line state and the queue; min_fraction_digits returns to 2.
// Stall:
//   A result waits in the output register while m_tready is low; bytes keep
//   being accepted until the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subtitle_timing_line_parser_top #(
  parameter int  TIME_BITS = 48,
  localparam int OUT_W     = ((TIME_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // char_code
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // status [1:0], start_ms, zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data   // min_fraction_digits
);
  import stlp_pkg::*;

  logic       min_frac;
  logic [1:0] min_frac_digits;
  token_t     front_tok;
  token_t     back_tok;
  logic       front_valid;
  logic       front_ready;
  logic       back_valid;
  logic       back_ready;

  assign cfg_ready = 1'b1;
  assign min_frac  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frac_digits <= 2'd2;
    end else if (min_frac) begin
      min_frac_digits <= cfg_data;
    end
  end

  stlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .tok_valid (front_valid),
    .tok_ready (front_ready),
    .tok       (front_tok)
  );

  stlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_tok    (front_tok),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_tok   (back_tok)
  );

  stlp_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (back_valid),
    .tok_ready (back_ready),
    .tok       (back_tok),
    .min_frac  (min_frac_digits),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== src/stlp_checker.sv =====
// ----------------------------------------------------------------------------
// stlp_checker
// Port-level assertions for the subtitle timing line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "subtitle_timing_line_parser_top_assert.svh"

module stlp_checker #(
  parameter int  TIME_BITS = 48,
  localparam int OUT_W     = ((TIME_BITS + 2 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);
  import stlp_pkg::*;

  logic [1:0]           out_status;
  logic [TIME_BITS-1:0] out_ms;

  assign out_status = m_tdata[1:0];
  assign out_ms     = m_tdata[TIME_BITS+1:2];

  `STLP_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid && s_tready, "not idle after reset")
  `STLP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat lost")
  `STLP_ASSERT(a_ms_zero, m_tvalid && out_status != STATUS_OK |-> out_ms == '0, "time on bad line")
  `STLP_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata >> (TIME_BITS + 2)) == '0, "pad bits set")

endmodule

bind subtitle_timing_line_parser_top stlp_checker #(.TIME_BITS(TIME_BITS)) u_stlp_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for subtitle_timing_line_parser_top
// Streams cue lines byte by byte into the parser and checks every status and
// start time beat against a line-level predictor that runs on each accepted
// byte. A short directed set is followed by random lines under several
// min_fraction_digits settings and idle patterns, including a long output
// stall that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import stlp_pkg::*;

  localparam int TIME_BITS = 48;
  localparam int OUT_W = ((TIME_BITS + 2 + 7) / 8) * 8;
  localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 60;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {P_LEAD, P_INT, P_FLEAD, P_FRAC} scan_phase_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } line_byte_t;

  typedef struct {
    status_t               status;
    logic [TIME_BITS-1:0]  ms;
  } cue_timing_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_data = '0;

  subtitle_timing_line_parser_top #(.TIME_BITS(TIME_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  line_byte_t  line_bytes[$];
  cue_timing_t expected_timings[$];
  logic [7:0]  line_buf[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_started = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;

  // line scanner state
  logic [1:0]        min_frac = 2'd2;
  scan_phase_t       ph = P_LEAD;
  int unsigned       colons = 0;
  longint unsigned   fld[3] = '{0, 0, 0};
  bit                have_digit = 0;
  int unsigned       frac_val = 0;
  int unsigned       frac_cnt = 0;
  bit                space_held = 0;
  int unsigned       dashes = 0;
  bit                bad_form = 0;
  bit                too_big = 0;
  bit                arrow = 0;

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic longint unsigned scale_add(longint unsigned a, longint unsigned k,
                                                longint unsigned b);
    if (a > (TIME_MAX - b) / k) begin
      too_big = 1'b1;
      return TIME_MAX;
    end
    return a * k + b;
  endfunction

  function automatic void clear_line_state();
    ph = P_LEAD;
    colons = 0;
    fld = '{0, 0, 0};
    have_digit = 0;
    frac_val = 0;
    frac_cnt = 0;
    space_held = 0;
    dashes = 0;
    bad_form = 0;
    too_big = 0;
    arrow = 0;
  endfunction

  function automatic void scan_stamp_char(logic [7:0] c);
    int unsigned slot;
    if (ph == P_LEAD) begin
      if (is_space(c)) return;
      ph = P_INT;
    end
    if (ph == P_INT) begin
      if (is_digit(c)) begin
        slot = (colons > 2) ? 2 : colons;
        fld[slot] = scale_add(fld[slot], 10, c - CH_ZERO);
        have_digit = 1;
      end else if (c == CH_COLON) begin
        if (!have_digit || colons >= 2) bad_form = 1;
        else colons++;
        have_digit = 0;
      end else if (c == CH_DOT || c == CH_COMMA) begin
        if (!have_digit) bad_form = 1;
        ph = P_FLEAD;
      end else begin
        bad_form = 1;
      end
      return;
    end
    if (ph == P_FLEAD) begin
      if (is_space(c)) return;
      ph = P_FRAC;
    end
    if (frac_cnt >= 3) return;
    if (is_space(c)) begin
      space_held = 1;
      return;
    end
    if (space_held) bad_form = 1;
    space_held = 0;
    if (is_digit(c)) frac_val = frac_val * 10 + (c - CH_ZERO);
    else bad_form = 1;
    frac_cnt++;
  endfunction

  function automatic void track_line_byte(logic [7:0] c, logic last);
    cue_timing_t     r;
    longint unsigned hrs, mins, secs, total;
    int unsigned     frac;
    if (!arrow) begin
      if (c == CH_DASH) begin
        if (dashes >= 2) scan_stamp_char(CH_DASH);
        else dashes++;
      end else if (c == CH_GT && dashes >= 2) begin
        arrow = 1;
        dashes = 0;
      end else begin
        while (dashes > 0) begin
          scan_stamp_char(CH_DASH);
          dashes--;
        end
        scan_stamp_char(c);
      end
    end
    if (!last) return;
    r.ms = '0;
    if (!arrow) begin
      r.status = STATUS_NO_ARROW;
    end else begin
      if (ph < P_FLEAD || frac_cnt < min_frac) bad_form = 1;
      frac = frac_val;
      for (int n = frac_cnt; n < 3; n++) frac *= 10;
      hrs = 0;
      mins = 0;
      secs = fld[0];
      if (colons == 1) begin
        mins = fld[0];
        secs = fld[1];
      end else if (colons >= 2) begin
        hrs = fld[0];
        mins = fld[1];
        secs = fld[2];
      end
      total = scale_add(hrs, 60, mins);
      total = scale_add(total, 60, secs);
      total = scale_add(total, 1000, frac);
      if (bad_form) begin
        r.status = STATUS_MALFORMED;
      end else if (too_big) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        r.status = STATUS_OK;
        r.ms = total[TIME_BITS-1:0];
      end
    end
    expected_timings.insert(expected_timings.size(), r);
    clear_line_state();
  endfunction

  // line builders
  function automatic void put_ch(logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return 8'd10;
      3: return 8'd11;
      4: return 8'd12;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void put_digits(int unsigned n);
    repeat (n) put_ch(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void build_cue_line();
    int unsigned nf;
    nf = ($urandom_range(0, 15) == 0) ? 4 : $urandom_range(1, 3);
    repeat ($urandom_range(0, 2)) put_ch(rand_ws());
    for (int f = 0; f < nf; f++) begin
      if (f != 0) put_ch(CH_COLON);
      put_digits(($urandom_range(0, 19) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 2));
    end
    put_ch($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
    if ($urandom_range(0, 9) == 0) put_ch(rand_ws());
    put_digits(($urandom_range(0, 9) < 6) ? 3 : $urandom_range(0, 5));
    repeat ($urandom_range(0, 2)) put_ch(rand_ws());
    case ($urandom_range(0, 9))
      0: put_text("--->");
      1: put_text("->");
      default: put_text("-->");
    endcase
    repeat ($urandom_range(0, 6)) put_ch(8'($urandom_range(0, 255)));
  endfunction

  function automatic void break_cue_line();
    int unsigned pos;
    logic [7:0]  c;
    pos = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 4))
      0: c = rand_ws();
      1: c = CH_COLON;
      2: c = CH_DASH;
      3: c = CH_DOT;
      default: c = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 3) == 0) line_buf.delete(pos);
    else line_buf.insert(pos, c);
  endfunction

  function automatic void build_noise_line();
    repeat ($urandom_range(1, 10)) put_ch(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0) put_text("-->");
  endfunction

  function automatic void queue_line();
    line_byte_t b;
    foreach (line_buf[i]) begin
      b.code = line_buf[i];
      b.last = (i == line_buf.size() - 1);
      line_bytes.insert(line_bytes.size(), b);
    end
    line_buf.delete();
  endfunction

  task automatic write_min_frac(input logic [1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_frac = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (line_bytes.size() != 0 || s_tvalid || expected_timings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin : drive_bytes
    line_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (line_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = line_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.code;
        s_tlast  <= nxt.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_started != holds_asked) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) track_line_byte(s_tdata, s_tlast);
  end

  always @(posedge clk) begin : check_timings
    cue_timing_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_timings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d start_ms %0d",
                   m_tdata[1:0], m_tdata[TIME_BITS+1:2]);
      end else begin
        want = expected_timings.pop_front();
        if (m_tdata[1:0] !== want.status || m_tdata[TIME_BITS+1:2] !== want.ms ||
            m_tdata[OUT_W-1:TIME_BITS+2] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want status %0d ms %0d, got status %0d ms %0d pad %0h",
                     want.status, want.ms, m_tdata[1:0], m_tdata[TIME_BITS+1:2],
                     m_tdata[OUT_W-1:TIME_BITS+2]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("subtitle_timing_line_parser_top test failed");
      $finish;
    end
  end

  initial begin : run_phases
    logic [1:0]  cfg_plan[7];
    int unsigned send_plan[7];
    int unsigned recv_plan[7];
    int unsigned n;
    int unsigned kind;
    cfg_plan  = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
    send_plan = '{0, 56, 0, 19, 56, 0, 19};
    recv_plan = '{0, 0, 56, 19, 0, 56, 19};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    put_text("1:2:3.45-->");
    queue_line();
    put_text("-->");
    queue_line();
    put_text("5.999--->");
    queue_line();
    put_ch(8'hFF);
    queue_line();
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_min_frac(cfg_plan[p]);
      @(negedge clk);
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      if (p == 3) holds_asked++;
      n = 0;
      while (n < PHASE_BYTES) begin
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
          build_cue_line();
          if (kind >= 70) break_cue_line();
        end else begin
          build_noise_line();
        end
        n += line_buf.size();
        queue_line();
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_timings.size() == 0)
      $display("subtitle_timing_line_parser_top test passed");
    else
      $display("subtitle_timing_line_parser_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/stlp_pkg.sv
src/stlp_front.sv
src/stlp_queue.sv
src/stlp_back.sv
src/subtitle_timing_line_parser_top.sv
src/stlp_checker.sv
bench/testbench.sv
